@@ rtl/dwsp_pkg.sv @@
// shared constants, register index codes and control types for the
// dual wheel speed controller; no dependencies
package dwsp_pkg;

	localparam int SPEED_WIDTH     = 16;
	localparam int SUM_WIDTH       = 32;
	localparam int DUTY_WIDTH      = 10;
	localparam int GAIN_WIDTH      = 16;
	localparam int PWM_WIDTH       = 10;
	localparam int FRAC_BITS       = 12;
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int CFG_DATA_WIDTH  = 16;

	// magnitude of the most negative speed needs one more bit, the error one more
	localparam int ERR_WIDTH  = SPEED_WIDTH + 2;
	localparam int DIFF_WIDTH = ERR_WIDTH + 1;
	localparam int SAT_WIDTH  = ((SUM_WIDTH > ERR_WIDTH) ? SUM_WIDTH : ERR_WIDTH) + 1;
	localparam int ACC_WIDTH  = GAIN_WIDTH + ((SUM_WIDTH > DIFF_WIDTH) ? SUM_WIDTH : DIFF_WIDTH) + 3;
	localparam int LIM_WIDTH  = (PWM_WIDTH > DUTY_WIDTH) ? PWM_WIDTH : DUTY_WIDTH;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_KP_LEFT  = CFG_INDEX_WIDTH'(0);
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_KI_LEFT  = CFG_INDEX_WIDTH'(1);
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_KD_LEFT  = CFG_INDEX_WIDTH'(2);
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_KP_RIGHT = CFG_INDEX_WIDTH'(3);
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_KI_RIGHT = CFG_INDEX_WIDTH'(4);
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_KD_RIGHT = CFG_INDEX_WIDTH'(5);
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_PWM_MAX  = CFG_INDEX_WIDTH'(6);

	localparam logic [GAIN_WIDTH-1:0] KP_LEFT_RST  = GAIN_WIDTH'(67);
	localparam logic [GAIN_WIDTH-1:0] KI_LEFT_RST  = GAIN_WIDTH'(0);
	localparam logic [GAIN_WIDTH-1:0] KD_LEFT_RST  = GAIN_WIDTH'(430);
	localparam logic [GAIN_WIDTH-1:0] KP_RIGHT_RST = GAIN_WIDTH'(67);
	localparam logic [GAIN_WIDTH-1:0] KI_RIGHT_RST = GAIN_WIDTH'(0);
	localparam logic [GAIN_WIDTH-1:0] KD_RIGHT_RST = GAIN_WIDTH'(422);
	localparam logic [PWM_WIDTH-1:0]  PWM_MAX_RST  = PWM_WIDTH'(400);

	typedef struct packed {
		logic load_s1;
		logic load_s2;
	} dwsp_ctl_t;

endpackage

@@ rtl/dwsp_if.sv @@
// request, result and register write channels of the speed controller
// depends on dwsp_pkg
interface dwsp_cmd_if import dwsp_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [SPEED_WIDTH-1:0] desired_left_rpm;
	logic signed [SPEED_WIDTH-1:0] desired_right_rpm;
	logic signed [SPEED_WIDTH-1:0] measured_left_rpm;
	logic signed [SPEED_WIDTH-1:0] measured_right_rpm;

	modport source (output valid, desired_left_rpm, desired_right_rpm,
		measured_left_rpm, measured_right_rpm, input ready);
	modport sink (input valid, desired_left_rpm, desired_right_rpm,
		measured_left_rpm, measured_right_rpm, output ready);
endinterface

interface dwsp_rsp_if import dwsp_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [DUTY_WIDTH-1:0] left_duty;
	logic [DUTY_WIDTH-1:0] right_duty;
	logic                  left_reverse;
	logic                  right_reverse;

	modport source (output valid, left_duty, right_duty, left_reverse, right_reverse,
		input ready);
	modport sink (input valid, left_duty, right_duty, left_reverse, right_reverse,
		output ready);
endinterface

interface dwsp_cfg_if import dwsp_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [CFG_INDEX_WIDTH-1:0] index;
	logic [CFG_DATA_WIDTH-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/dwsp_lane.sv @@
// one wheel lane: error, saturating error sum and pid products in stage 1,
// duty accumulate, clamp and rounding in stage 2; depends on dwsp_pkg
module dwsp_lane import dwsp_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dwsp_ctl_t                     ctl,
	input  logic signed [SPEED_WIDTH-1:0] desired,
	input  logic signed [SPEED_WIDTH-1:0] measured,
	input  logic [GAIN_WIDTH-1:0]         kp,
	input  logic [GAIN_WIDTH-1:0]         ki,
	input  logic [GAIN_WIDTH-1:0]         kd,
	input  logic [DUTY_WIDTH-1:0]         limit,
	output logic [DUTY_WIDTH-1:0]         duty,
	output logic                          reverse
);

	logic signed [SUM_WIDTH-1:0]              err_sum_q;
	logic signed [ERR_WIDTH-1:0]              last_err_q;
	logic [DUTY_WIDTH-1:0]                    duty_q;
	logic signed [ACC_WIDTH-1:0]              pid_s1;
	logic                                     rev_s1;
	logic                                     rev_s2;

	logic signed [ERR_WIDTH-1:0]              des_x;
	logic signed [ERR_WIDTH-1:0]              mag;
	logic signed [ERR_WIDTH-1:0]              err;
	logic signed [DIFF_WIDTH-1:0]             diff;
	logic signed [GAIN_WIDTH+ERR_WIDTH:0]     p_prod;
	logic signed [GAIN_WIDTH+SUM_WIDTH:0]     i_prod;
	logic signed [GAIN_WIDTH+DIFF_WIDTH:0]    d_prod;
	logic signed [ACC_WIDTH-1:0]              pid;
	logic signed [SAT_WIDTH-1:0]              sum_w;
	logic signed [SUM_WIDTH-1:0]              sum_sat;

	logic signed [ACC_WIDTH:0]                acc;
	logic signed [ACC_WIDTH:0]                lim_sh;
	logic [DUTY_WIDTH+1:0]                    rq;
	logic [DUTY_WIDTH-1:0]                    duty_next;

	// stage 1: error terms and products
	always_comb begin
		des_x  = ERR_WIDTH'(desired);
		mag    = des_x[ERR_WIDTH-1] ? -des_x : des_x;
		err    = mag - ERR_WIDTH'(measured);
		diff   = DIFF_WIDTH'(err) - DIFF_WIDTH'(last_err_q);
		p_prod = $signed({1'b0, kp}) * err;
		i_prod = $signed({1'b0, ki}) * err_sum_q;
		d_prod = $signed({1'b0, kd}) * diff;
		pid    = ACC_WIDTH'(p_prod) + ACC_WIDTH'(i_prod) + ACC_WIDTH'(d_prod);
		sum_w  = SAT_WIDTH'(err_sum_q) + SAT_WIDTH'(err);
		// saturate when the upper bits do not all match the sign
		if (sum_w[SAT_WIDTH-1:SUM_WIDTH-1] == '0 || sum_w[SAT_WIDTH-1:SUM_WIDTH-1] == '1) begin
			sum_sat = sum_w[SUM_WIDTH-1:0];
		end else begin
			sum_sat = {sum_w[SAT_WIDTH-1], {(SUM_WIDTH-1){~sum_w[SAT_WIDTH-1]}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_sum_q  <= '0;
			last_err_q <= '0;
		end else if (ctl.load_s1) begin
			err_sum_q  <= sum_sat;
			last_err_q <= err;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s1) begin
			pid_s1 <= pid;
			rev_s1 <= desired[SPEED_WIDTH-1];
		end
	end

	// stage 2: add to stored duty, clamp, round half up
	always_comb begin
		acc    = (ACC_WIDTH+1)'($signed({1'b0, duty_q, {FRAC_BITS{1'b0}}})) +
			(ACC_WIDTH+1)'(pid_s1);
		lim_sh = (ACC_WIDTH+1)'($signed({1'b0, limit, {FRAC_BITS{1'b0}}}));
		rq     = ({1'b0, acc[FRAC_BITS+DUTY_WIDTH-1:FRAC_BITS-1]} + (DUTY_WIDTH+2)'(1)) >> 1;
		priority if (acc <= 0) begin
			duty_next = '0;
		end else if (acc >= lim_sh) begin
			duty_next = limit;
		end else if (rq > (DUTY_WIDTH+2)'(limit)) begin
			duty_next = limit;
		end else begin
			duty_next = rq[DUTY_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q <= '0;
		end else if (ctl.load_s2) begin
			duty_q <= duty_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s2) begin
			rev_s2 <= rev_s1;
		end
	end

	assign duty    = duty_q;
	assign reverse = rev_s2;

endmodule

@@ rtl/dual_wheel_speed_pid.sv @@
// dual wheel incremental pid speed controller, top level
// depends on dwsp_pkg, dwsp_if and dwsp_lane
//
// usage:
// - cmd carries one control tick: signed desired and measured speed of both
//   wheels, q12.4 rpm; a request is taken when cmd.valid and cmd.ready are high
// - rsp returns one result per request: duty and reverse flag for each wheel
// - cfg writes the gain registers and pwm_max; cfg.ready is always high, and
//   writes belong in idle time between ticks
// - two lanes, one per wheel, run side by side; the output register merges them
// - a request passes the stage 1 register, then the output register, to rsp
// - throughput: one request per cycle while rsp does not stall; the duty feedback
//   closes within stage 2 and the error sum within stage 1, so neither limits it
// - when rsp stalls, the result holds and one more request can still enter
//   stage 1; only then does cmd.ready drop
// - reset clears error sums, last errors and duties to zero and loads the
//   default gains and pwm_max of 400
module dual_wheel_speed_pid import dwsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	dwsp_cmd_if.sink   cmd,
	dwsp_rsp_if.source rsp,
	dwsp_cfg_if.sink   cfg
);

	// gain and clamp registers
	logic [GAIN_WIDTH-1:0] kp_left_q;
	logic [GAIN_WIDTH-1:0] ki_left_q;
	logic [GAIN_WIDTH-1:0] kd_left_q;
	logic [GAIN_WIDTH-1:0] kp_right_q;
	logic [GAIN_WIDTH-1:0] ki_right_q;
	logic [GAIN_WIDTH-1:0] kd_right_q;
	logic [PWM_WIDTH-1:0]  pwm_max_q;

	logic                  v_s1_q;
	logic                  v_s2_q;
	logic                  out_free;
	dwsp_ctl_t             ctl;
	logic [LIM_WIDTH-1:0]  lim_w;
	logic [DUTY_WIDTH-1:0] limit;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_left_q  <= KP_LEFT_RST;
			ki_left_q  <= KI_LEFT_RST;
			kd_left_q  <= KD_LEFT_RST;
			kp_right_q <= KP_RIGHT_RST;
			ki_right_q <= KI_RIGHT_RST;
			kd_right_q <= KD_RIGHT_RST;
			pwm_max_q  <= PWM_MAX_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_KP_LEFT:  kp_left_q  <= cfg.data[GAIN_WIDTH-1:0];
				REG_KI_LEFT:  ki_left_q  <= cfg.data[GAIN_WIDTH-1:0];
				REG_KD_LEFT:  kd_left_q  <= cfg.data[GAIN_WIDTH-1:0];
				REG_KP_RIGHT: kp_right_q <= cfg.data[GAIN_WIDTH-1:0];
				REG_KI_RIGHT: ki_right_q <= cfg.data[GAIN_WIDTH-1:0];
				REG_KD_RIGHT: kd_right_q <= cfg.data[GAIN_WIDTH-1:0];
				REG_PWM_MAX:  pwm_max_q  <= cfg.data[PWM_WIDTH-1:0];
				default: ;   // unknown index, write dropped
			endcase
		end
	end

	// clamp also limited to the largest duty code
	always_comb begin
		lim_w = (LIM_WIDTH'(pwm_max_q) > LIM_WIDTH'((1 << DUTY_WIDTH) - 1))
			? LIM_WIDTH'((1 << DUTY_WIDTH) - 1) : LIM_WIDTH'(pwm_max_q);
		limit = lim_w[DUTY_WIDTH-1:0];
	end

	// pipeline flow: stage 2 is the output register
	assign out_free    = !v_s2_q || rsp.ready;
	assign cmd.ready   = !v_s1_q || out_free;
	assign ctl.load_s1 = cmd.valid && cmd.ready;
	assign ctl.load_s2 = v_s1_q && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
		end else begin
			if (ctl.load_s1) begin
				v_s1_q <= 1'b1;
			end else if (ctl.load_s2) begin
				v_s1_q <= 1'b0;
			end
			if (ctl.load_s2) begin
				v_s2_q <= 1'b1;
			end else if (rsp.ready) begin
				v_s2_q <= 1'b0;
			end
		end
	end

	// left and right lanes
	dwsp_lane u_lane_left (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.desired  (cmd.desired_left_rpm),
		.measured (cmd.measured_left_rpm),
		.kp       (kp_left_q),
		.ki       (ki_left_q),
		.kd       (kd_left_q),
		.limit    (limit),
		.duty     (rsp.left_duty),
		.reverse  (rsp.left_reverse)
	);

	dwsp_lane u_lane_right (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.desired  (cmd.desired_right_rpm),
		.measured (cmd.measured_right_rpm),
		.kp       (kp_right_q),
		.ki       (ki_right_q),
		.kd       (kd_right_q),
		.limit    (limit),
		.duty     (rsp.right_duty),
		.reverse  (rsp.right_reverse)
	);

	assign rsp.valid = v_s2_q;

	// duties never exceed the clamp
	a_duty_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.left_duty <= limit) && (rsp.right_duty <= limit))
		else $error("duty above clamp");

	// an accepted request always lands in stage 1
	a_s1_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_s1 |=> v_s1_q)
		else $error("request lost entering stage 1");

	// a stalled stage 1 keeps its request and the output stays full
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1_q && !out_free) |=> (v_s1_q && v_s2_q))
		else $error("stalled request dropped");

	// a stage 1 move always produces a result
	a_s2_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_s2 |=> rsp.valid)
		else $error("result lost entering output register");

endmodule

@@ test/dual_wheel_speed_pid_tb.sv @@
// self-checking bench for the dual wheel speed controller: directed and random
// control ticks, gain and clamp writes between phases, error sum windup runs
// depends on dwsp_pkg, dwsp_if and the dual_wheel_speed_pid rtl
module dual_wheel_speed_pid_tb;
	import dwsp_pkg::*;

	// index 7 maps to no register, writes there must be dropped
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNMAPPED = CFG_INDEX_WIDTH'(7);
	localparam int QUIET_LIMIT  = 2000;
	localparam int REPORT_LIMIT = 200;
	localparam int PHASE_TICKS  = 80;
	// short full scale runs that push the error sum toward either rail
	localparam int WINDUP_TICKS = 10;

	typedef logic signed [SPEED_WIDTH-1:0] rpm_t;
	typedef struct packed {
		rpm_t want_l;
		rpm_t want_r;
		rpm_t seen_l;
		rpm_t seen_r;
	} tick_t;
	typedef struct packed {
		logic [DUTY_WIDTH-1:0] duty_l;
		logic [DUTY_WIDTH-1:0] duty_r;
		logic                  rev_l;
		logic                  rev_r;
	} drive_t;

	// tracks gains, clamp and per wheel loop state; holds the drive values
	// still owed by the block, oldest first
	class speed_loop_tracker;
		logic [GAIN_WIDTH-1:0] kp[2];
		logic [GAIN_WIDTH-1:0] ki[2];
		logic [GAIN_WIDTH-1:0] kd[2];
		logic [PWM_WIDTH-1:0]  duty_cap;
		longint                err_sum[2];
		longint                err_prev[2];
		longint                duty_now[2];
		drive_t                owed_drive[$];
		int                    errors;

		function new();
			kp[0] = KP_LEFT_RST;
			ki[0] = KI_LEFT_RST;
			kd[0] = KD_LEFT_RST;
			kp[1] = KP_RIGHT_RST;
			ki[1] = KI_RIGHT_RST;
			kd[1] = KD_RIGHT_RST;
			duty_cap = PWM_MAX_RST;
			for (int w = 0; w < 2; w++) begin
				err_sum[w] = 0;
				err_prev[w] = 0;
				duty_now[w] = 0;
			end
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_INDEX_WIDTH-1:0] idx,
				logic [CFG_DATA_WIDTH-1:0] val);
			case (idx)
				REG_KP_LEFT:  kp[0] = val[GAIN_WIDTH-1:0];
				REG_KI_LEFT:  ki[0] = val[GAIN_WIDTH-1:0];
				REG_KD_LEFT:  kd[0] = val[GAIN_WIDTH-1:0];
				REG_KP_RIGHT: kp[1] = val[GAIN_WIDTH-1:0];
				REG_KI_RIGHT: ki[1] = val[GAIN_WIDTH-1:0];
				REG_KD_RIGHT: kd[1] = val[GAIN_WIDTH-1:0];
				REG_PWM_MAX:  duty_cap = val[PWM_WIDTH-1:0];
				default: ;
			endcase
		endfunction

		// one incremental pid step of one wheel, q.12 accumulator
		function logic [DUTY_WIDTH-1:0] advance_wheel(int w, rpm_t want, rpm_t seen,
				output logic rev);
			longint mag, err, acc, sum, cap, top, bottom, full;
			top = (longint'(1) <<< (SUM_WIDTH - 1)) - 1;
			bottom = -top - 1;
			full = (longint'(1) <<< DUTY_WIDTH) - 1;
			cap = longint'(duty_cap);
			if (cap > full)
				cap = full;
			rev = want < 0;
			mag = (want < 0) ? -longint'(want) : longint'(want);
			err = mag - longint'(seen);
			// integral term uses the sum before this tick
			acc = duty_now[w] <<< FRAC_BITS;
			acc += longint'(kp[w]) * err;
			acc += longint'(ki[w]) * err_sum[w];
			acc += longint'(kd[w]) * (err - err_prev[w]);
			sum = err_sum[w] + err;
			if (sum > top)
				sum = top;
			if (sum < bottom)
				sum = bottom;
			err_sum[w] = sum;
			err_prev[w] = err;
			if (acc <= 0)
				duty_now[w] = 0;
			else if (acc >= (cap <<< FRAC_BITS))
				duty_now[w] = cap;
			else begin
				// round half up
				duty_now[w] = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
				if (duty_now[w] > cap)
					duty_now[w] = cap;
			end
			return DUTY_WIDTH'(duty_now[w]);
		endfunction

		function void take_tick(tick_t t);
			drive_t d;
			d.duty_l = advance_wheel(0, t.want_l, t.seen_l, d.rev_l);
			d.duty_r = advance_wheel(1, t.want_r, t.seen_r, d.rev_r);
			owed_drive.push_back(d);
		endfunction

		function void report_field(string name, logic [DUTY_WIDTH-1:0] want,
				logic [DUTY_WIDTH-1:0] got);
			errors++;
			if (errors <= REPORT_LIMIT)
				$display("%0t mismatch on %s: expected %0d, actual %0d",
					$time, name, want, got);
		endfunction

		function void match_output(drive_t got);
			drive_t want;
			if (owed_drive.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("%0t unexpected result: expected none, actual %h", $time, got);
				return;
			end
			want = owed_drive.pop_front();
			if (want.duty_l !== got.duty_l)
				report_field("left_duty", want.duty_l, got.duty_l);
			if (want.duty_r !== got.duty_r)
				report_field("right_duty", want.duty_r, got.duty_r);
			if (want.rev_l !== got.rev_l)
				report_field("left_reverse", DUTY_WIDTH'(want.rev_l), DUTY_WIDTH'(got.rev_l));
			if (want.rev_r !== got.rev_r)
				report_field("right_reverse", DUTY_WIDTH'(want.rev_r), DUTY_WIDTH'(got.rev_r));
		endfunction

		function int pending();
			return owed_drive.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   sender_gaps = 1'b1;
	bit   sink_stalls = 1'b1;
	int   stall_left = 0;
	int   quiet_cycles = 0;

	speed_loop_tracker loop_model = new();

	dwsp_cmd_if cmd_ch();
	dwsp_rsp_if rsp_ch();
	dwsp_cfg_if cfg_ch();

	dual_wheel_speed_pid i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	always #2 clk = ~clk;

	// idle lengths: mostly a few cycles, now and then a long one
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 8);
		return $urandom_range(10, 40);
	endfunction

	// result side back pressure; ready is held low while in reset
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left <= idle_length() - 1;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// handshake monitor: register writes, requests and results, all seen at the edge
	always @(posedge clk) begin
		if (cfg_ch.valid && cfg_ch.ready)
			loop_model.write_reg(cfg_ch.index, cfg_ch.data);
		if (cmd_ch.valid && cmd_ch.ready)
			loop_model.take_tick(tick_t'({cmd_ch.desired_left_rpm, cmd_ch.desired_right_rpm,
				cmd_ch.measured_left_rpm, cmd_ch.measured_right_rpm}));
		if (rsp_ch.valid && rsp_ch.ready)
			loop_model.match_output(drive_t'({rsp_ch.left_duty, rsp_ch.right_duty,
				rsp_ch.left_reverse, rsp_ch.right_reverse}));
	end

	// watchdog: too long without any handshake means the block hung
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic tick_t tick_of(int dl, int dr, int ml, int mr);
		tick_t t;
		t.want_l = rpm_t'(dl);
		t.want_r = rpm_t'(dr);
		t.seen_l = rpm_t'(ml);
		t.seen_r = rpm_t'(mr);
		return t;
	endfunction

	// wheel running near its setpoint, where the duty stays off the rails
	function automatic void near_setpoint(output rpm_t want, output rpm_t seen);
		int mag, s;
		mag = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 4000);
		s = mag + $urandom_range(0, 800) - 400;
		if (s > 32767)
			s = 32767;
		if (s < -32768)
			s = -32768;
		want = $urandom_range(0, 1) ? rpm_t'(-mag) : rpm_t'(mag);
		seen = rpm_t'(s);
	endfunction

	function automatic rpm_t corner_rpm();
		case ($urandom_range(0, 5))
			0: return rpm_t'(-32768);
			1: return rpm_t'(-1);
			2: return rpm_t'(0);
			3: return rpm_t'(1);
			4: return rpm_t'(16);
			default: return rpm_t'(32767);
		endcase
	endfunction

	function automatic tick_t random_tick();
		tick_t t;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			near_setpoint(t.want_l, t.seen_l);
			near_setpoint(t.want_r, t.seen_r);
		end else if (pick < 85) begin
			t = tick_t'({$urandom, $urandom});
		end else begin
			t.want_l = corner_rpm();
			t.want_r = corner_rpm();
			t.seen_l = corner_rpm();
			t.seen_r = corner_rpm();
		end
		return t;
	endfunction

	// one request; valid stays up afterwards so back to back requests need no gap
	task automatic send_tick(tick_t t);
		int gap;
		gap = (sender_gaps && $urandom_range(0, 2) == 0) ? idle_length() : 0;
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.desired_left_rpm <= t.want_l;
		cmd_ch.desired_right_rpm <= t.want_r;
		cmd_ch.measured_left_rpm <= t.seen_l;
		cmd_ch.measured_right_rpm <= t.seen_r;
		do @(posedge clk); while (!cmd_ch.ready);
	endtask

	// stop sending and let every owed result come back; checked at the falling
	// edge so the monitor has already seen the last rising one
	task automatic wait_drained();
		cmd_ch.valid <= 1'b0;
		do @(negedge clk); while (loop_model.pending() != 0);
		@(posedge clk);
	endtask

	task automatic write_reg_req(logic [CFG_INDEX_WIDTH-1:0] idx,
			logic [CFG_DATA_WIDTH-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	// full register set, written only with the block idle
	task automatic load_settings(logic [15:0] kpl, logic [15:0] kil, logic [15:0] kdl,
			logic [15:0] kpr, logic [15:0] kir, logic [15:0] kdr, logic [15:0] cap);
		wait_drained();
		write_reg_req(REG_KP_LEFT, kpl);
		write_reg_req(REG_KI_LEFT, kil);
		write_reg_req(REG_KD_LEFT, kdl);
		write_reg_req(REG_KP_RIGHT, kpr);
		write_reg_req(REG_KI_RIGHT, kir);
		write_reg_req(REG_KD_RIGHT, kdr);
		write_reg_req(REG_PWM_MAX, cap);
		// unmapped index, must leave every register alone
		write_reg_req(REG_UNMAPPED, 16'($urandom));
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic run_random(int count);
		sender_gaps = $urandom_range(0, 3) != 0;
		sink_stalls = $urandom_range(0, 3) != 0;
		for (int n = 0; n < count; n++) begin
			// occasional full pause of the sender mid phase
			if ($urandom_range(0, 39) == 0)
				wait_drained();
			send_tick(random_tick());
		end
	endtask

	initial begin
		cmd_ch.valid = 1'b0;
		cmd_ch.desired_left_rpm = '0;
		cmd_ch.desired_right_rpm = '0;
		cmd_ch.measured_left_rpm = '0;
		cmd_ch.measured_right_rpm = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed ticks on the reset gains and clamp
		send_tick(tick_of(0, 0, 0, 0));
		// forward left, reverse right near 100 rpm, repeated for the d and i history
		send_tick(tick_of(16 * 100, -16 * 100, 16 * 90, 16 * 110));
		send_tick(tick_of(16 * 100, -16 * 100, 16 * 95, 16 * 104));
		send_tick(tick_of(16 * 100, -16 * 100, 16 * 101, 16 * 99));
		// large positive error, duty pinned at the clamp
		send_tick(tick_of(32767, 32767, 0, 0));
		// most negative desired, magnitude 32768 against the most negative measure
		send_tick(tick_of(-32768, -32768, -32768, -32768));
		send_tick(tick_of(-32768, 32767, 32767, -32768));
		// large negative error, duty floors at zero
		send_tick(tick_of(0, 0, 32767, 32767));
		send_tick(tick_of(0, 0, -32768, -32768));
		send_tick(tick_of(-1, 1, 0, 0));
		send_tick(tick_of(1, -1, 1, -1));
		send_tick(tick_of(32767, -32768, -32768, 32767));
		send_tick(tick_of(16 * 50, 16 * 50, 16 * 50, 16 * 50));
		send_tick(tick_of(16 * 50, 16 * 50, 16 * 48, 16 * 52));
		send_tick(tick_of(-16 * 50, -16 * 50, 16 * 50, 16 * 50));

		// moderate gains with some integral action
		load_settings(16'($urandom_range(0, 300)), 16'($urandom_range(1, 20)),
			16'($urandom_range(0, 600)), 16'($urandom_range(0, 300)),
			16'($urandom_range(1, 20)), 16'($urandom_range(0, 600)),
			16'($urandom_range(200, 600)));
		run_random(PHASE_TICKS);

		// all zero, clamp at zero
		load_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		run_random(PHASE_TICKS);

		// all ones, upper clamp bits beyond the register width dropped
		load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		run_random(PHASE_TICKS);

		// unconstrained register values
		load_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom), 16'($urandom));
		run_random(PHASE_TICKS);

		// small gains, full duty range
		load_settings(16'($urandom_range(0, 64)), 16'($urandom_range(0, 8)),
			16'($urandom_range(0, 64)), 16'($urandom_range(0, 64)),
			16'($urandom_range(0, 8)), 16'($urandom_range(0, 64)), 16'h03FF);
		run_random(PHASE_TICKS);

		// default gains back, small integral term
		load_settings(KP_LEFT_RST, 16'd2, KD_LEFT_RST, KP_RIGHT_RST, 16'd2, KD_RIGHT_RST,
			16'(PWM_MAX_RST));
		run_random(PHASE_TICKS);

		// error sum windup: full scale negative error pushes the sum toward its
		// lower rail, then full scale positive error pulls it back up
		load_settings(16'($urandom_range(0, 100)), 16'($urandom_range(1, 8)),
			16'($urandom_range(0, 100)), 16'($urandom_range(0, 100)),
			16'($urandom_range(1, 8)), 16'($urandom_range(0, 100)),
			16'($urandom_range(1, 1023)));
		sender_gaps = 1'b0;
		sink_stalls = 1'b0;
		repeat (WINDUP_TICKS)
			send_tick(tick_of(int'($urandom_range(0, 30)) - 15, int'($urandom_range(0, 30)) - 15,
				32767, 32767));
		repeat (WINDUP_TICKS)
			send_tick(tick_of(-32768, -32768, -int'($urandom_range(32700, 32768)),
				-int'($urandom_range(32700, 32768))));
		// unwind under normal traffic
		run_random(PHASE_TICKS / 2);

		wait_drained();
		// let any stray result show up
		repeat (4) @(posedge clk);
		if (loop_model.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/dwsp_pkg.sv
rtl/dwsp_if.sv
rtl/dwsp_lane.sv
rtl/dual_wheel_speed_pid.sv
test/dual_wheel_speed_pid_tb.sv
